### rtl/core/i2cms_pkg.sv
// Shared types, codes and sizing constants of the I2C master transfer sequencer.
package i2cms_pkg;

	// Buffer slots: slot 0 holds the address byte, data bytes follow from slot 1.
	localparam int BUFFER_DEPTH = 16;
	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	// Wide enough to hold the depth itself, since the pointer saturates there.
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	// Compare width for count+1 and index+1 against the depth.
	localparam int CMP_W = 9;
	localparam int RX_INDEX_W = 4;

	localparam logic RW_WRITE_BIT = 1'b0;
	localparam logic RW_READ_BIT = 1'b1;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_EVENT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_SEND    = 3'd2,
		ACT_RX_ACK  = 3'd3,
		ACT_RX_NACK = 3'd4,
		ACT_STOP    = 3'd5,
		ACT_RESTART = 3'd6,
		ACT_RELEASE = 3'd7
	} action_t;

	// Bus engine status codes; the remaining codes all mean "release the bus".
	localparam logic [3:0] ST_START     = 4'd0;
	localparam logic [3:0] ST_RSTART    = 4'd1;
	localparam logic [3:0] ST_SLAW_ACK  = 4'd2;
	localparam logic [3:0] ST_SLAW_NACK = 4'd3;
	localparam logic [3:0] ST_TX_ACK    = 4'd4;
	localparam logic [3:0] ST_TX_NACK   = 4'd5;
	localparam logic [3:0] ST_ARB_LOST  = 4'd6;
	localparam logic [3:0] ST_SLAR_ACK  = 4'd7;
	localparam logic [3:0] ST_SLAR_NACK = 4'd8;
	localparam logic [3:0] ST_RX_ACK    = 4'd9;
	localparam logic [3:0] ST_RX_NACK   = 4'd10;
	localparam logic [3:0] ST_BUS_ERR   = 4'd11;
	localparam logic [3:0] ST_OTHER     = 4'd12;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] target_address;
		logic [7:0] byte_count;
		logic [7:0] data_byte;
		logic [3:0] data_index;
		logic [3:0] bus_status;
	} in_word_t;

	typedef struct packed {
		action_t                 action;
		logic [7:0]              tx_byte;
		logic                    accepted;
		logic                    rx_valid;
		logic [RX_INDEX_W-1:0]   rx_index;
		logic [7:0]              rx_byte;
		logic                    ready_res;
		logic                    transfer_ok;
	} out_word_t;

	// Buffer access issued by the control logic for one word.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

### rtl/core/i2cms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// Read data holds until the next read.
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/i2cms_ctrl.sv
// Transfer state and per-word decision logic of the sequencer.
module i2cms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  i2cms_pkg::in_word_t  item,
	output i2cms_pkg::mem_req_t  mem_req,
	output i2cms_pkg::out_word_t result,
	output logic                 send
);
	import i2cms_pkg::*;

	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] send_len_q, send_len_d;
	logic [CNT_W-1:0] recv_len_q, recv_len_d;
	logic             busy_q, busy_d;
	logic             ok_q, ok_d;
	logic [CMP_W-1:0] load_slot;
	logic [CMP_W-1:0] total;
	logic [CNT_W-1:0] base_ptr;
	logic [CNT_W-1:0] bumped_ptr;
	logic             base_has_byte;
	logic             ptr_in_range;

	always_comb begin
		load_slot = CMP_W'(item.data_index) + CMP_W'(1);
		total = CMP_W'(item.byte_count) + CMP_W'(1);
		// A START or repeated START rewinds to the address byte.
		base_ptr = (item.bus_status == ST_START || item.bus_status == ST_RSTART)
			? '0 : ptr_q;
		base_has_byte = (base_ptr < send_len_q) && (base_ptr < CNT_W'(BUFFER_DEPTH));
		ptr_in_range = ptr_q < CNT_W'(BUFFER_DEPTH);
		bumped_ptr = ptr_in_range ? ptr_q + CNT_W'(1) : ptr_q;
	end

	always_comb begin
		ptr_d = ptr_q;
		send_len_d = send_len_q;
		recv_len_d = recv_len_q;
		busy_d = busy_q;
		ok_d = ok_q;
		send = 1'b0;
		mem_req = '0;
		result = '0;
		result.action = ACT_NONE;

		unique case (item.kind)
			KIND_LOAD: begin
				if (!busy_q && load_slot < CMP_W'(BUFFER_DEPTH)) begin
					mem_req.wr_en = 1'b1;
					mem_req.wr_addr = ADDR_W'(load_slot);
					mem_req.wr_data = item.data_byte;
				end
			end
			KIND_WRITE, KIND_READ: begin
				if (!busy_q && total <= CMP_W'(BUFFER_DEPTH)) begin
					busy_d = 1'b1;
					ok_d = 1'b0;
					ptr_d = '0;
					mem_req.wr_en = 1'b1;
					mem_req.wr_addr = '0;
					if (item.kind == KIND_WRITE) begin
						mem_req.wr_data = {item.target_address, RW_WRITE_BIT};
						send_len_d = CNT_W'(total);
						recv_len_d = '0;
					end else begin
						// A read sends its address byte only.
						mem_req.wr_data = {item.target_address, RW_READ_BIT};
						send_len_d = CNT_W'(1);
						recv_len_d = CNT_W'(total);
					end
					result.accepted = 1'b1;
					result.action = ACT_START;
				end
			end
			KIND_EVENT: begin
				if (busy_q) begin
					unique case (item.bus_status) inside
						ST_START, ST_RSTART, ST_SLAW_ACK, ST_TX_ACK: begin
							if (base_has_byte) begin
								mem_req.rd_en = 1'b1;
								mem_req.rd_addr = base_ptr[ADDR_W-1:0];
								send = 1'b1;
								ptr_d = base_ptr + CNT_W'(1);
								result.action = ACT_SEND;
							end else begin
								ptr_d = base_ptr;
								busy_d = 1'b0;
								ok_d = 1'b1;
								result.action = ACT_STOP;
							end
						end
						ST_RX_ACK: begin
							if (ptr_in_range) begin
								mem_req.wr_en = 1'b1;
								mem_req.wr_addr = ptr_q[ADDR_W-1:0];
								mem_req.wr_data = item.data_byte;
								result.rx_valid = 1'b1;
								result.rx_index = RX_INDEX_W'(ptr_q);
								result.rx_byte = item.data_byte;
							end
							ptr_d = bumped_ptr;
							result.action = ((CNT_W + 1)'(bumped_ptr) + (CNT_W + 1)'(1)
								< (CNT_W + 1)'(recv_len_q)) ? ACT_RX_ACK : ACT_RX_NACK;
						end
						ST_SLAR_ACK: begin
							result.action = ((CNT_W + 1)'(ptr_q) + (CNT_W + 1)'(1)
								< (CNT_W + 1)'(recv_len_q)) ? ACT_RX_ACK : ACT_RX_NACK;
						end
						ST_RX_NACK: begin
							if (ptr_in_range) begin
								mem_req.wr_en = 1'b1;
								mem_req.wr_addr = ptr_q[ADDR_W-1:0];
								mem_req.wr_data = item.data_byte;
								result.rx_valid = 1'b1;
								result.rx_index = RX_INDEX_W'(ptr_q);
								result.rx_byte = item.data_byte;
							end
							busy_d = 1'b0;
							ok_d = 1'b1;
							result.action = ACT_STOP;
						end
						ST_ARB_LOST: begin
							result.action = ACT_RESTART;
						end
						default: begin
							busy_d = 1'b0;
							result.action = ACT_RELEASE;
						end
					endcase
				end
			end
			default: begin
				result.action = ACT_NONE;
			end
		endcase

		result.ready_res = !busy_d;
		result.transfer_ok = ok_d;
		mem_req.wr_en = mem_req.wr_en && take;
		mem_req.rd_en = mem_req.rd_en && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			send_len_q <= '0;
			recv_len_q <= '0;
			busy_q <= 1'b0;
			ok_q <= 1'b0;
		end else if (take) begin
			ptr_q <= ptr_d;
			send_len_q <= send_len_d;
			recv_len_q <= recv_len_d;
			busy_q <= busy_d;
			ok_q <= ok_d;
		end
	end

	a_ptr_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= CNT_W'(BUFFER_DEPTH))
		else $error("byte pointer beyond buffer depth");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.wr_en && mem_req.rd_en))
		else $error("buffer read and write issued by the same word");

	a_read_is_send: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> busy_q && result.action == ACT_SEND)
		else $error("buffer read without a send while busy");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && take && item.kind == KIND_EVENT |=> !busy_q && $stable(ptr_q))
		else $error("event while idle changed transfer state");

endmodule

### rtl/core/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: control, byte buffer and result register.
//
//   Channel | Direction | Handshake            | Word
//   --------+-----------+----------------------+---------------------------
//   req     | in        | req_valid/req_ready  | i2cms_pkg::in_word_t
//   rsp     | out       | rsp_valid/rsp_ready  | i2cms_pkg::out_word_t
//
// One word is taken per cycle while req_ready is high; each gives a registered result word.
// The decision for a word is made in the cycle it is taken; the buffer read for a send
// is registered like the result, and its read data appears together with the result.
// Reset clears the transfer state; the byte buffer itself is not cleared.
// A stalled result holds in the result register and the buffer read data, and
// req_ready stays high as long as the result register is empty or being drained.
module i2c_master_transfer_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  i2cms_pkg::in_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output i2cms_pkg::out_word_t rsp
);
	import i2cms_pkg::*;

	logic      take;
	mem_req_t  mem_req;
	out_word_t result;
	logic      send;
	logic [7:0] rd_data;

	logic      valid_s1;
	out_word_t res_s1;
	logic      send_s1;

	// A new word enters whenever the result register is free or draining this cycle.
	assign req_ready = !valid_s1 || rsp_ready;
	assign take = req_valid && req_ready;

	// Decides the action, updates pointer, lengths and flags, and issues
	// at most one buffer access per word.
	i2cms_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.item    (req),
		.mem_req (mem_req),
		.result  (result),
		.send    (send)
	);

	// Byte buffer: address byte in slot 0, write or received data from slot 1.
	i2cms_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= result;
			send_s1 <= send;
		end
	end

	// The byte to send arrives from the buffer in the cycle after the decision;
	// it is merged into the result word here.
	always_comb begin
		rsp = res_s1;
		if (send_s1) begin
			rsp.tx_byte = rd_data;
		end
	end

	assign rsp_valid = valid_s1;

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid)
		else $error("accepted word produced no result");

	a_accept_is_start: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |-> rsp.action == ACT_START && !rsp.ready_res)
		else $error("accepted start without START action or while idle");

	a_rx_action: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.rx_valid |->
			(rsp.action == ACT_RX_ACK || rsp.action == ACT_RX_NACK || rsp.action == ACT_STOP))
		else $error("received byte stored outside a receive step");

endmodule

### tb/sequencer_checker.sv
// Checker that predicts and compares every result word of the I2C master transfer sequencer.
`timescale 1ns / 1ps
module sequencer_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  i2cms_pkg::in_word_t  req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  i2cms_pkg::out_word_t rsp,
	output int                   error_count,
	output int                   pending_count
);
	import i2cms_pkg::*;

	// Shadow of the sequencer: buffer slots, pointer, lengths and the two flags.
	logic [7:0]  slot_mem [BUFFER_DEPTH];
	int unsigned byte_ptr = 0;
	int unsigned send_len = 0;
	int unsigned recv_len = 0;
	bit          busy = 1'b0;
	bit          last_ok = 1'b0;

	out_word_t   expected_words [$];
	out_word_t   want;

	initial begin
		error_count = 0;
		pending_count = 0;
	end

	// Sends the byte under the pointer, or ends the transfer with a stop.
	function automatic void next_send(inout out_word_t r);
		if (byte_ptr < send_len && byte_ptr < BUFFER_DEPTH) begin
			r.tx_byte = slot_mem[byte_ptr];
			byte_ptr++;
			r.action = ACT_SEND;
		end else begin
			busy = 1'b0;
			last_ok = 1'b1;
			r.action = ACT_STOP;
		end
	endfunction

	// Stores a received byte unless the pointer has run off the buffer.
	function automatic void store_received(input logic [7:0] value, inout out_word_t r);
		if (byte_ptr < BUFFER_DEPTH) begin
			slot_mem[byte_ptr] = value;
			r.rx_valid = 1'b1;
			r.rx_index = RX_INDEX_W'(byte_ptr);
			r.rx_byte = value;
		end
	endfunction

	function automatic action_t next_receive();
		return (byte_ptr + 1 < recv_len) ? ACT_RX_ACK : ACT_RX_NACK;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t   r;
		int unsigned total;
		r = '0;
		total = int'(w.byte_count) + 1;
		case (w.kind)
		KIND_LOAD: begin
			if (!busy && int'(w.data_index) + 1 < BUFFER_DEPTH)
				slot_mem[int'(w.data_index) + 1] = w.data_byte;
		end
		KIND_WRITE, KIND_READ: begin
			if (!busy && total <= BUFFER_DEPTH) begin
				busy = 1'b1;
				last_ok = 1'b0;
				byte_ptr = 0;
				slot_mem[0] = {w.target_address,
					(w.kind == KIND_READ) ? RW_READ_BIT : RW_WRITE_BIT};
				// A read only ever sends its address byte.
				send_len = (w.kind == KIND_READ) ? 1 : total;
				recv_len = (w.kind == KIND_READ) ? total : 0;
				r.accepted = 1'b1;
				r.action = ACT_START;
			end
		end
		default: begin
			if (busy) begin
				case (w.bus_status)
				ST_START, ST_RSTART: begin
					byte_ptr = 0;
					next_send(r);
				end
				ST_SLAW_ACK, ST_TX_ACK: next_send(r);
				ST_RX_ACK: begin
					store_received(w.data_byte, r);
					if (byte_ptr < BUFFER_DEPTH)
						byte_ptr++;
					r.action = next_receive();
				end
				ST_SLAR_ACK: r.action = next_receive();
				ST_RX_NACK: begin
					store_received(w.data_byte, r);
					busy = 1'b0;
					last_ok = 1'b1;
					r.action = ACT_STOP;
				end
				ST_ARB_LOST: r.action = ACT_RESTART;
				default: begin
					busy = 1'b0;
					r.action = ACT_RELEASE;
				end
				endcase
			end
		end
		endcase
		r.ready_res = !busy;
		r.transfer_ok = last_ok;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			error_count++;
		end
	endfunction

	// Results are compared before the request of the same edge is predicted, so a
	// stray result can never be matched against a word taken in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ptr = 0;
			send_len = 0;
			recv_len = 0;
			busy = 1'b0;
			last_ok = 1'b0;
			expected_words.delete();
			pending_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with no expectation waiting: 0x%0h", rsp);
					error_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("action", 8'(want.action), 8'(rsp.action));
					check_field("tx_byte", want.tx_byte, rsp.tx_byte);
					check_field("accepted", 8'(want.accepted), 8'(rsp.accepted));
					check_field("rx_valid", 8'(want.rx_valid), 8'(rsp.rx_valid));
					check_field("rx_index", 8'(want.rx_index), 8'(rsp.rx_index));
					check_field("rx_byte", want.rx_byte, rsp.rx_byte);
					check_field("ready_res", 8'(want.ready_res), 8'(rsp.ready_res));
					check_field("transfer_ok", 8'(want.transfer_ok), 8'(rsp.transfer_ok));
				end
			end
			if (req_valid && req_ready)
				expected_words.push_back(predict_word(req));
			pending_count = expected_words.size();
		end
	end

endmodule

### tb/testbench.sv
// Top of the sequencer testbench: clock, reset, request and result traffic, and the verdict.
`timescale 1ns / 1ps
module testbench;
	import i2cms_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_word_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_word_t rsp;

	int        error_count;
	int        pending_count;
	// While calm is set neither side idles, so back-to-back words get exercised too.
	bit        calm;
	// Words sent with counts set; words sent with counts clear do not advance this.
	int        counted;

	always #6 clk = ~clk;

	i2c_master_transfer_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sequencer_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	// Fills every field at random, then pins the kind and the bus status. Fields
	// that the kind does not use stay random so that all their bits toggle.
	function automatic in_word_t random_word(kind_t k, logic [3:0] st);
		logic [63:0] raw;
		in_word_t    w;
		raw = {$urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		w.kind = k;
		w.bus_status = st;
		return w;
	endfunction

	// Presents one request word and returns at the edge where it is taken. Valid is
	// only dropped when a gap follows, so it never falls and rises in the same step.
	task automatic send_word(in_word_t w, bit counts);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (counts)
			counted++;
	endtask

	task automatic send_event(logic [3:0] st);
		send_word(random_word(KIND_EVENT, st), 1'b1);
	endtask

	task automatic send_start(bit is_read, logic [6:0] addr, logic [7:0] count);
		in_word_t w;
		w = random_word(is_read ? KIND_READ : KIND_WRITE, ST_START);
		w.target_address = addr;
		w.byte_count = count;
		send_word(w, 1'b1);
	endtask

	// Any of the codes that make the sequencer give up the bus, the codes above
	// the named range included.
	function automatic logic [3:0] release_code();
		case ($urandom_range(0, 4))
		0: return ST_SLAW_NACK;
		1: return ST_TX_NACK;
		2: return ST_SLAR_NACK;
		3: return ST_BUS_ERR;
		default: return 4'(ST_OTHER + $urandom_range(0, 3));
		endcase
	endfunction

	// One well-formed transfer as the bus engine would report it, with random
	// content. Now and then arbitration is lost and the whole exchange is replayed
	// after a repeated start, the transfer is abandoned with a release code, or a
	// request arrives that a busy sequencer must turn away.
	task automatic run_transfer(bit is_read);
		in_word_t   w;
		int         count;
		int         n_rx;
		int         last_step;
		int         step;
		int         pick;
		logic [3:0] open_code;
		logic [3:0] st;
		// Mostly lengths that fit; once in a while one that must be rejected.
		count = ($urandom_range(0, 19) == 0) ? $urandom_range(BUFFER_DEPTH, 255)
			: $urandom_range(0, BUFFER_DEPTH - 1);
		send_start(is_read, 7'($urandom), 8'(count));
		if (count >= BUFFER_DEPTH)
			return;
		// A read may ask for more bytes than were announced, which runs the pointer
		// past the end of the buffer when the length is at its maximum.
		n_rx = $urandom_range(0, count + 2);
		last_step = is_read ? n_rx + 2 : count + 1;
		open_code = ST_START;
		step = 0;
		while (step <= last_step) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_event(ST_ARB_LOST);
				open_code = ST_RSTART;
				step = 0;
			end else if (pick < 5) begin
				send_event(release_code());
				return;
			end else if (pick < 7) begin
				// A new start or a load while the transfer runs.
				w = random_word(kind_t'($urandom_range(0, 2)), 4'($urandom));
				send_word(w, w.kind != KIND_LOAD);
			end else begin
				if (step == 0)
					st = open_code;
				else if (step == 1)
					st = is_read ? ST_SLAR_ACK : ST_SLAW_ACK;
				else if (is_read)
					st = (step == last_step) ? ST_RX_NACK : ST_RX_ACK;
				else
					st = ST_TX_ACK;
				send_event(st);
				step++;
			end
		end
	endtask

	// Result side: before every result word a stall of random length, unless calm.
	initial begin
		int stall;
		rsp_ready = 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		in_word_t w;
		int       pick;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		counted = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The buffer is not cleared by reset, so every data slot is loaded before any
		// write can send it. The last index lies beyond the buffer and is dropped.
		for (int i = 0; i < 16; i++) begin
			w = random_word(KIND_LOAD, ST_START);
			w.data_index = 4'(i);
			w.data_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
			send_word(w, 1'b1);
		end
		// A bus event with nothing in progress is ignored.
		send_word(random_word(KIND_EVENT, ST_START), 1'b0);
		// Lengths that do not fit the buffer are rejected.
		send_start(1'b0, 7'h7F, 8'd16);
		send_start(1'b1, 7'h00, 8'hFF);
		// Shortest write at the top address, with a lost arbitration and a replay.
		send_start(1'b0, 7'h7F, 8'd0);
		send_event(ST_START);
		send_event(ST_ARB_LOST);
		send_event(ST_RSTART);
		send_event(ST_SLAW_ACK);
		// Shortest read at address zero: one byte, taken with a NACK.
		send_start(1'b1, 7'h00, 8'd0);
		send_event(ST_START);
		send_event(ST_SLAR_ACK);
		send_event(ST_RX_NACK);

		// Random part: mostly complete transfers, some buffer loads, a little noise.
		while (counted < 1750) begin
			if ($urandom_range(0, 24) == 0)
				calm = !calm;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// A word with every field random, then a release to leave the
				// sequencer idle in case the noise started a transfer.
				send_word(random_word(kind_t'($urandom_range(0, 3)), 4'($urandom)), 1'b0);
				send_word(random_word(KIND_EVENT, release_code()), 1'b0);
			end else if (pick < 25) begin
				repeat ($urandom_range(1, 4))
					send_word(random_word(KIND_LOAD, 4'($urandom)), 1'b1);
			end else begin
				run_transfer(1'($urandom_range(0, 1)));
			end
		end
		req_valid <= 1'b0;

		// Wait for the last results to drain, then keep watching for any stray word.
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("** i2c_master_transfer_sequencer: PASSED **");
		else
			$display("** i2c_master_transfer_sequencer: FAILED **");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("** i2c_master_transfer_sequencer: FAILED **");
		$finish;
	end

endmodule
